FILE: design/mcer_pkg.sv
// shared constants, types and helpers of the multi-channel echo ranger
package mcer_pkg;

	// channel count and timer width
	localparam int CHANNELS   = 3;
	localparam int TIMER_BITS = 16;

	// register widths and reset values
	localparam int MIN_W     = 16;
	localparam int TRIG_W    = 8;
	localparam int LIMIT_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [MIN_W-1:0]   MIN_PULSE_RST = MIN_W'(100);
	localparam logic [TRIG_W-1:0]  TRIGGER_RST   = TRIG_W'(10);
	localparam logic [LIMIT_W-1:0] LIMIT_RST     = '0;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_PULSE = 2'd0,
		REG_TRIGGER   = 2'd1,
		REG_OBSTACLE  = 2'd2
	} mcer_reg_t;

	// distance field
	localparam int DIST_W = 15;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// timer compare width covers both the timer and the minimum pulse register
	localparam int CMP_W = (TIMER_BITS > MIN_W) ? TIMER_BITS : MIN_W;

	// distance = floor((8 * t + 14) / 29), the divide done by a reciprocal multiply
	localparam int NUM_W       = TIMER_BITS + 4;
	localparam int RECIP_SHIFT = NUM_W + 5;
	localparam int RECIP_W     = TIMER_BITS + 5;
	localparam int PROD_W      = NUM_W + RECIP_W;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + 64'd28) / 64'd29;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
	localparam logic [NUM_W-1:0]   ROUND_BIAS = NUM_W'(14);

	// quotient compare width covers the quotient and the distance field
	localparam int QX_W = (TIMER_BITS > DIST_W) ? TIMER_BITS : DIST_W;

	// control of one lane for the current cycle
	typedef struct packed {
		logic accept;
		logic start;
		logic fin;
		logic adv_s2;
	} mcer_ctrl_t;

	// what a lane hands to the merging stage
	typedef struct packed {
		logic                  done;
		logic [TIMER_BITS-1:0] quot;
	} mcer_lane_t;

	// clamp a quotient to the distance field
	function automatic logic [DIST_W-1:0] sat_dist(input logic [TIMER_BITS-1:0] q);
		logic [QX_W-1:0] qx;
		qx = QX_W'(q);
		if (qx > QX_W'(DIST_MAX))
			return DIST_MAX;
		else
			return qx[DIST_W-1:0];
	endfunction

endpackage

FILE: design/mcer_if.sv
// channel interfaces: input ticks, result items and configuration writes

interface mcer_in_if;
	logic valid;
	logic ready;
	logic echo_0;
	logic echo_1;
	logic echo_2;
	logic start_cycle;
	logic finalize;

	modport source (output valid, echo_0, echo_1, echo_2, start_cycle, finalize,
		input ready);
	modport sink (input valid, echo_0, echo_1, echo_2, start_cycle, finalize,
		output ready);
endinterface

interface mcer_out_if;
	logic        valid;
	logic        ready;
	logic        trigger;
	logic        valid_0;
	logic [14:0] distance_0;
	logic        obstacle_0;
	logic        valid_1;
	logic [14:0] distance_1;
	logic        obstacle_1;
	logic        valid_2;
	logic [14:0] distance_2;
	logic        obstacle_2;

	modport source (output valid, trigger, valid_0, distance_0, obstacle_0,
		valid_1, distance_1, obstacle_1, valid_2, distance_2, obstacle_2,
		input ready);
	modport sink (input valid, trigger, valid_0, distance_0, obstacle_0,
		valid_1, distance_1, obstacle_1, valid_2, distance_2, obstacle_2,
		output ready);
endinterface

interface mcer_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/mcer_lane.sv
// one echo channel: edge detect, pulse timer, done flags and distance multiply
module mcer_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mcer_pkg::mcer_ctrl_t      ctrl,
	input  logic                      echo,
	input  logic [mcer_pkg::MIN_W-1:0] min_pulse_ticks,
	output mcer_pkg::mcer_lane_t      lane
);
	import mcer_pkg::*;

	localparam logic [TIMER_BITS-1:0] TMAX = '1;

	logic                  prev_q;
	logic [TIMER_BITS-1:0] timer_q;
	logic                  armed_q;
	logic [TIMER_BITS-1:0] travel_q;
	logic                  done_q;
	logic                  latched_q;

	logic                  rise;
	logic                  fall;
	logic                  armed_eff;
	logic                  done_eff;
	logic [TIMER_BITS-1:0] timer_inc;
	logic                  hit;
	logic                  done_next;

	logic [NUM_W-1:0]      num;
	logic [PROD_W-1:0]     prod;

	logic                  done_s2;
	logic [TIMER_BITS-1:0] quot_s2;

	// edge detect and the start strobe clearing the flags first
	always_comb begin
		rise      = echo & ~prev_q;
		fall      = ~echo & prev_q;
		armed_eff = armed_q & ~ctrl.start;
		done_eff  = done_q & ~ctrl.start;
		timer_inc = (timer_q == TMAX) ? timer_q : timer_q + 1'b1;
		hit       = fall & armed_eff & (CMP_W'(timer_inc) > CMP_W'(min_pulse_ticks));
		done_next = done_eff | (~rise & hit);
	end

	// channel state, updated once per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= 1'b0;
			timer_q   <= '0;
			armed_q   <= 1'b0;
			travel_q  <= '0;
			done_q    <= 1'b0;
			latched_q <= 1'b0;
		end else if (ctrl.accept) begin
			prev_q <= echo;
			done_q <= done_next;
			if (rise) begin
				timer_q <= '0;
				armed_q <= 1'b1;
			end else begin
				timer_q <= timer_inc;
				armed_q <= armed_eff;
				if (hit)
					travel_q <= timer_inc;
			end
			if (ctrl.fin)
				latched_q <= done_next;
		end
	end

	// rounded divide by 58 as a reciprocal multiply
	always_comb begin
		num  = {travel_q, 3'b000} + ROUND_BIAS;
		prod = PROD_W'(num) * PROD_W'(RECIP);
	end

	// second stage: flag and quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_s2 <= 1'b0;
		else if (ctrl.adv_s2)
			done_s2 <= latched_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv_s2)
			quot_s2 <= prod[RECIP_SHIFT +: TIMER_BITS];
	end

	assign lane.done = done_s2;
	assign lane.quot = quot_s2;

endmodule

FILE: design/mcer_merge.sv
// merging stage: clamp, obstacle compare and the result register
module mcer_merge (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           valid_s2,
	input  logic                                           trig_s2,
	input  mcer_pkg::mcer_lane_t [mcer_pkg::CHANNELS-1:0]  lanes,
	input  logic [mcer_pkg::LIMIT_W-1:0]                   obstacle_limit,
	output logic                                           ready_out,
	mcer_out_if.source                                     result_out
);
	import mcer_pkg::*;

	logic                               out_valid_q;
	logic                               load;
	logic [CHANNELS-1:0][DIST_W-1:0]    chan_dist;
	logic [CHANNELS-1:0]                obst;

	logic                               trig_q;
	logic [CHANNELS-1:0]                done_q;
	logic [CHANNELS-1:0][DIST_W-1:0]    dist_q;
	logic [CHANNELS-1:0]                obst_q;

	assign ready_out = ~out_valid_q | result_out.ready;
	assign load      = valid_s2 & ready_out;

	// per channel distance and obstacle flag
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			chan_dist[c] = lanes[c].done ? sat_dist(lanes[c].quot) : '0;
			obst[c] = lanes[c].done && (chan_dist[c] != '0) &&
				(LIMIT_W'(chan_dist[c]) <= obstacle_limit);
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ready_out)
			out_valid_q <= valid_s2;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			trig_q <= trig_s2;
			for (int c = 0; c < CHANNELS; c++) begin
				done_q[c] <= lanes[c].done;
				dist_q[c] <= chan_dist[c];
				obst_q[c] <= obst[c];
			end
		end
	end

	assign result_out.valid      = out_valid_q;
	assign result_out.trigger    = trig_q;
	assign result_out.valid_0    = done_q[0];
	assign result_out.distance_0 = dist_q[0];
	assign result_out.obstacle_0 = obst_q[0];
	assign result_out.valid_1    = done_q[1];
	assign result_out.distance_1 = dist_q[1];
	assign result_out.obstacle_1 = obst_q[1];
	assign result_out.valid_2    = done_q[2];
	assign result_out.distance_2 = dist_q[2];
	assign result_out.obstacle_2 = obst_q[2];

endmodule

FILE: design/multi_channel_echo_ranger_top.sv
// top level of the three-channel ultrasonic echo ranger
//
//  channel     dir  payload
//  item_in     in   echo_0..2, start_cycle, finalize (one microsecond tick)
//  result_out  out  trigger, valid/distance/obstacle per channel
//  cfg         in   index (2 bit), data (16 bit), always ready
//
// one tick is taken every clock while result_out does not stall; channel state
// updates at the input transfer and the result is offered after the lane
// multiply stage and the result register. the divide by 58 is one reciprocal
// multiply per lane, registered before the compare.
// a stall of result_out reaches item_in.ready combinationally: with the
// pipeline full, ready drops in the same cycle and three ticks wait inside.
// reset clears valids, flags and config; quotient, trigger and result payload are not reset.
module multi_channel_echo_ranger_top (
	input  logic        clk,
	input  logic        arst_n,
	mcer_in_if.sink     item_in,
	mcer_out_if.source  result_out,
	mcer_cfg_if.sink    cfg
);
	import mcer_pkg::*;

	logic [MIN_W-1:0]   min_pulse_q;
	logic [TRIG_W-1:0]  trig_ticks_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [TRIG_W-1:0]  trig_rem_q;

	logic [TRIG_W-1:0]  trig_eff;
	logic               trig_now;

	logic               valid_s1;
	logic               trig_s1;
	logic               valid_s2;
	logic               trig_s2;
	logic               ready_s2;
	logic               ready_out;
	logic               accept;

	mcer_ctrl_t                ctrl;
	logic [CHANNELS-1:0]       echo;
	mcer_lane_t [CHANNELS-1:0] lanes;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q  <= MIN_PULSE_RST;
			trig_ticks_q <= TRIGGER_RST;
			limit_q      <= LIMIT_RST;
		end else if (cfg.valid) begin
			case (mcer_reg_t'(cfg.index))
				REG_MIN_PULSE: min_pulse_q  <= cfg.data[MIN_W-1:0];
				REG_TRIGGER:   trig_ticks_q <= cfg.data[TRIG_W-1:0];
				REG_OBSTACLE:  limit_q      <= cfg.data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline handshake
	assign ready_s2      = ~valid_s2 | ready_out;
	assign item_in.ready = ~valid_s1 | ready_s2;
	assign accept        = item_in.valid & item_in.ready;

	assign ctrl.accept = accept;
	assign ctrl.start  = item_in.start_cycle;
	assign ctrl.fin    = item_in.finalize;
	assign ctrl.adv_s2 = valid_s1 & ready_s2;

	// trigger pulse counter, loaded by the start strobe
	assign trig_eff = item_in.start_cycle ? trig_ticks_q : trig_rem_q;
	assign trig_now = (trig_eff != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			trig_rem_q <= '0;
		else if (accept)
			trig_rem_q <= trig_now ? trig_eff - 1'b1 : '0;
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_in.ready)
				valid_s1 <= item_in.valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	// trigger level travelling with the item
	always_ff @(posedge clk) begin
		if (accept)
			trig_s1 <= trig_now;
		if (ctrl.adv_s2)
			trig_s2 <= trig_s1;
	end

	// lanes, one per echo channel
	assign echo = {item_in.echo_2, item_in.echo_1, item_in.echo_0};

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		mcer_lane u_lane (
			.clk             (clk),
			.arst_n          (arst_n),
			.ctrl            (ctrl),
			.echo            (echo[c]),
			.min_pulse_ticks (min_pulse_q),
			.lane            (lanes[c])
		);
	end

	// merge and result register
	mcer_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s2       (valid_s2),
		.trig_s2        (trig_s2),
		.lanes          (lanes),
		.obstacle_limit (limit_q),
		.ready_out      (ready_out),
		.result_out     (result_out)
	);

endmodule

FILE: tb/multi_channel_echo_ranger_top_tb.sv
// self-checking testbench of the three-channel echo ranger: predictor, stimulus and checks
`timescale 1ns / 100ps

module multi_channel_echo_ranger_top_tb;
	import mcer_pkg::*;

	localparam int RESET_CYCLES = 11;
	localparam int PIPE_SETTLE  = 8;
	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 120;
	localparam int RANDOM_ITEMS = 1250;
	localparam int PHASE_ITEMS  = 200;
	localparam int N_DIRECTED   = 23;

	// register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// register values after reset
	localparam logic [15:0] MIN_ECHO_AT_RESET = 16'd100;
	localparam logic [7:0]  TRIG_AT_RESET     = 8'd10;
	localparam logic [15:0] LIMIT_AT_RESET    = 16'd0;

	// directed ticks as {finalize, start_cycle, echo_2, echo_1, echo_0}
	localparam logic [4:0] DIRECTED_TICKS [N_DIRECTED] = '{
		5'b01000, 5'b00111, 5'b00111, 5'b00011, 5'b00011, 5'b00001,
		5'b10001, 5'b01001, 5'b01001, 5'b00000, 5'b11000, 5'b00111,
		5'b00110, 5'b00100, 5'b00000, 5'b10000, 5'b00111, 5'b00111,
		5'b00111, 5'b00111, 5'b00000, 5'b10000, 5'b01000
	};

	// one reading as the block reports it
	typedef struct packed {
		logic                             trigger;
		logic [CHANNELS-1:0]              vld;
		logic [CHANNELS-1:0][DIST_W-1:0] distance;
		logic [CHANNELS-1:0]              obst;
	} ranging_reading_t;

	// echo timing predictor and queue of readings still to come
	class ranging_scoreboard;
		logic                  echo_prev    [CHANNELS];
		logic [TIMER_BITS-1:0] pulse_age    [CHANNELS];
		logic                  armed_flag   [CHANNELS];
		logic [TIMER_BITS-1:0] travel_ticks [CHANNELS];
		logic                  done_flag    [CHANNELS];
		logic                  shown_done   [CHANNELS];
		logic [7:0]            trigger_left;
		logic [15:0]           min_echo_ticks;
		logic [7:0]            trigger_width;
		logic [15:0]           obstacle_limit;
		ranging_reading_t      awaited_readings [$];
		int                    mismatches;
		int                    readings_checked;

		function new();
			for (int c = 0; c < CHANNELS; c++) begin
				echo_prev[c]    = 1'b0;
				pulse_age[c]    = '0;
				armed_flag[c]   = 1'b0;
				travel_ticks[c] = '0;
				done_flag[c]    = 1'b0;
				shown_done[c]   = 1'b0;
			end
			trigger_left     = '0;
			min_echo_ticks   = MIN_ECHO_AT_RESET;
			trigger_width    = TRIG_AT_RESET;
			obstacle_limit   = LIMIT_AT_RESET;
			mismatches       = 0;
			readings_checked = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_MIN_PULSE: min_echo_ticks = data;
				REG_TRIGGER:   trigger_width  = data[7:0];
				REG_OBSTACLE:  obstacle_limit = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return awaited_readings.size();
		endfunction

		// travel ticks to sixteenths of a centimetre, rounded half up
		function logic [DIST_W-1:0] to_sixteenths(logic [TIMER_BITS-1:0] ticks);
			int unsigned q;
			q = (32'(ticks) * 32'd16 + 32'd29) / 32'd58;
			if (q > 32'h7FFF)
				q = 32'h7FFF;
			return q[DIST_W-1:0];
		endfunction

		// one accepted tick: start, then echo edges, then finalize
		function void note_tick(logic [CHANNELS-1:0] echo, logic start, logic fin);
			ranging_reading_t want;
			if (start) begin
				for (int c = 0; c < CHANNELS; c++) begin
					armed_flag[c] = 1'b0;
					done_flag[c]  = 1'b0;
				end
				trigger_left = trigger_width;
			end
			for (int c = 0; c < CHANNELS; c++) begin
				if (echo[c] && !echo_prev[c]) begin
					pulse_age[c]  = '0;
					armed_flag[c] = 1'b1;
				end else begin
					if (pulse_age[c] != '1)
						pulse_age[c] = pulse_age[c] + 1'b1;
					if (!echo[c] && echo_prev[c] && armed_flag[c] &&
							pulse_age[c] > min_echo_ticks) begin
						travel_ticks[c] = pulse_age[c];
						done_flag[c]    = 1'b1;
					end
				end
				echo_prev[c] = echo[c];
			end
			if (fin) begin
				for (int c = 0; c < CHANNELS; c++)
					shown_done[c] = done_flag[c];
			end
			want.trigger = (trigger_left != '0);
			if (trigger_left != '0)
				trigger_left = trigger_left - 1'b1;
			for (int c = 0; c < CHANNELS; c++) begin
				want.vld[c]      = shown_done[c];
				want.distance[c] = shown_done[c] ? to_sixteenths(travel_ticks[c]) : '0;
				want.obst[c]     = shown_done[c] && (want.distance[c] != '0) &&
					(want.distance[c] <= obstacle_limit);
			end
			awaited_readings.push_back(want);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		// compare one reading with the oldest one awaited
		task check_reading(ranging_reading_t got);
			ranging_reading_t want;
			readings_checked++;
			if (awaited_readings.size() == 0) begin
				report($sformatf("reading %0d arrived with none awaited", readings_checked));
				return;
			end
			want = awaited_readings.pop_front();
			if (got.trigger !== want.trigger)
				report($sformatf("reading %0d trigger: got %0b, want %0b",
					readings_checked, got.trigger, want.trigger));
			for (int c = 0; c < CHANNELS; c++) begin
				if (got.vld[c] !== want.vld[c])
					report($sformatf("reading %0d valid_%0d: got %0b, want %0b",
						readings_checked, c, got.vld[c], want.vld[c]));
				if (got.distance[c] !== want.distance[c])
					report($sformatf("reading %0d distance_%0d: got %0d, want %0d",
						readings_checked, c, got.distance[c], want.distance[c]));
				if (got.obst[c] !== want.obst[c])
					report($sformatf("reading %0d obstacle_%0d: got %0b, want %0b",
						readings_checked, c, got.obst[c], want.obst[c]));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	mcer_in_if  item_in ();
	mcer_out_if result_out ();
	mcer_cfg_if cfg ();

	multi_channel_echo_ranger_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.result_out (result_out),
		.cfg        (cfg)
	);

	ranging_scoreboard sb = new();

	int items_sent;
	int burst_left;
	int cfg_writes;
	int settings_used;
	bit hold_request;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// every transfer feeds the scoreboard, ticks before readings
	always @(posedge clk) begin : transfer_monitor
		ranging_reading_t got;
		if (arst_n) begin
			if (item_in.valid && item_in.ready)
				sb.note_tick({item_in.echo_2, item_in.echo_1, item_in.echo_0},
					item_in.start_cycle, item_in.finalize);
			if (cfg.valid && cfg.ready)
				sb.set_register(cfg.index, cfg.data);
			if (result_out.valid && result_out.ready) begin
				got.trigger  = result_out.trigger;
				got.vld      = {result_out.valid_2, result_out.valid_1, result_out.valid_0};
				got.distance = {result_out.distance_2, result_out.distance_1,
					result_out.distance_0};
				got.obst     = {result_out.obstacle_2, result_out.obstacle_1,
					result_out.obstacle_0};
				sb.check_reading(got);
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_in.valid && item_in.ready) || (cfg.valid && cfg.ready) ||
					(result_out.valid && result_out.ready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// result sink: stall modes of random length, long hold-off on request
	initial begin : result_sink
		int mode;
		int left;
		mode = 0;
		left = 0;
		result_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(3, 0);
				left = $urandom_range(80, 16);
			end
			left--;
			case (mode)
				0: result_out.ready <= 1'b1;
				1: result_out.ready <= 1'($urandom_range(1, 0));
				2: result_out.ready <= (left % 4 == 0);
				default: result_out.ready <= ($urandom_range(7, 0) != 0);
			endcase
		end
	end

	// offer one tick, in bursts with random gaps, and wait for its transfer
	task automatic send_tick(input logic [CHANNELS-1:0] echo, input logic start,
			input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(50, 1);
			gap = ($urandom_range(9, 0) < 4) ? 0 : $urandom_range(8, 1);
			if (gap > 0) begin
				item_in.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		item_in.valid       <= 1'b1;
		item_in.echo_0      <= echo[0];
		item_in.echo_1      <= echo[1];
		item_in.echo_2      <= echo[2];
		item_in.start_cycle <= start;
		item_in.finalize    <= fin;
		@(posedge clk);
		while (!item_in.ready)
			@(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// stop offering and wait for every awaited reading
	task automatic drain();
		item_in.valid <= 1'b0;
		burst_left = 0;
		// let the monitor note the last transfer first
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg_writes++;
	endtask

	task automatic apply_setting(input logic [CFG_DAT_W-1:0] min_val,
			input logic [CFG_DAT_W-1:0] trig_val, input logic [CFG_DAT_W-1:0] limit_val);
		drain();
		write_reg(REG_MIN_PULSE, min_val);
		write_reg(REG_TRIGGER, trig_val);
		write_reg(REG_OBSTACLE, limit_val);
		cfg.valid <= 1'b0;
		settings_used++;
	endtask

	// start, at most one echo pulse per channel, around the minimum unless it is large, then finalize
	task automatic measure_cycle();
		int rise [CHANNELS];
		int fall [CHANNELS];
		int dur;
		int span;
		int unsigned mn;
		logic [CHANNELS-1:0] lv;
		mn = sb.min_echo_ticks;
		span = 0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (mn > 200)
				dur = $urandom_range(40, 1);
			else if ($urandom_range(3, 0) == 0 && mn > 0)
				dur = $urandom_range(mn, 1);
			else
				dur = mn + $urandom_range(12, 1);
			rise[c] = $urandom_range(6, 0);
			fall[c] = rise[c] + dur;
			if ($urandom_range(7, 0) == 0) begin
				rise[c] = -1;
				fall[c] = -1;
			end
			if (fall[c] > span)
				span = fall[c];
		end
		span += $urandom_range(3, 0);
		for (int k = 0; k <= span; k++) begin
			for (int c = 0; c < CHANNELS; c++)
				lv[c] = (k >= rise[c]) && (k < fall[c]);
			// an occasional glitch breaks the pulse
			if ($urandom_range(39, 0) == 0)
				lv[$urandom_range(CHANNELS - 1, 0)] ^= 1'b1;
			send_tick(lv, k == 0, 1'b0);
		end
		send_tick('0, $urandom_range(5, 0) == 0, 1'b1);
		repeat ($urandom_range(3, 0)) send_tick('0, 1'b0, 1'b0);
	endtask

	// unstructured ticks
	task automatic noise_burst();
		repeat ($urandom_range(20, 4))
			send_tick(CHANNELS'($urandom_range(7, 0)), $urandom_range(7, 0) == 0,
				$urandom_range(7, 0) == 0);
	endtask

	task automatic pick_setting(input int phase);
		case (phase)
			0: apply_setting(16'(MIN_ECHO_AT_RESET), 16'(TRIG_AT_RESET), 16'(LIMIT_AT_RESET));
			1: begin
				apply_setting(16'hFFFF, 16'h00FF, 16'h0000);
				hold_request = 1'b1;
			end
			3: begin
				apply_setting(16'h0000, 16'h0001, 16'hFFFF);
				hold_request = 1'b1;
			end
			4: apply_setting(16'($urandom_range(30, 0)), 16'hA500, 16'($urandom_range(25, 0)));
			default: apply_setting(16'($urandom_range(30, 0)),
				{8'($urandom_range(255, 0)), 8'($urandom_range(40, 1))},
				16'($urandom_range(25, 0)));
		endcase
	endtask

	// reset, stimulus and verdict
	initial begin : stimulus
		int random_base;
		int next_switch;
		int phase;
		items_sent    = 0;
		burst_left    = 0;
		cfg_writes    = 0;
		settings_used = 1;
		hold_request  = 1'b0;
		arst_n              <= 1'b0;
		item_in.valid       <= 1'b0;
		item_in.echo_0      <= 1'b0;
		item_in.echo_1      <= 1'b0;
		item_in.echo_2      <= 1'b0;
		item_in.start_cycle <= 1'b0;
		item_in.finalize    <= 1'b0;
		cfg.valid           <= 1'b0;
		cfg.index           <= '0;
		cfg.data            <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: short pulses, restarts, start with finalize, spare index
		apply_setting(16'd2, 16'd3, 16'd3);
		write_reg(REG_SPARE, '1);
		cfg.valid <= 1'b0;
		for (int i = 0; i < N_DIRECTED; i++)
			send_tick(DIRECTED_TICKS[i][2:0], DIRECTED_TICKS[i][3], DIRECTED_TICKS[i][4]);

		// zero trigger width and a pulse that rounds to zero distance
		apply_setting(16'd0, 16'h0100, 16'd0);
		send_tick(3'b000, 1'b1, 1'b0);
		send_tick(3'b111, 1'b0, 1'b0);
		send_tick(3'b000, 1'b0, 1'b0);
		send_tick(3'b000, 1'b0, 1'b1);

		// random measurement cycles and noise over rotating settings
		random_base = items_sent;
		next_switch = items_sent;
		phase = 0;
		while (items_sent - random_base < RANDOM_ITEMS) begin
			if (items_sent >= next_switch) begin
				pick_setting(phase);
				phase++;
				next_switch = items_sent + PHASE_ITEMS;
			end
			if ($urandom_range(4, 0) == 0)
				noise_burst();
			else
				measure_cycle();
		end

		drain();
		$display("covered %0d ticks of directed, noise and echo cycles, %0d readings checked",
			items_sent, sb.readings_checked);
		$display("%0d register transfers over %0d settings, %0d mismatches",
			cfg_writes, settings_used, sb.mismatches);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
